// ----- hdl/hsel_pkg.sv -----
// Shared types and constants for the heap top-tenth selector.
package hsel_pkg;

  localparam int DEF_MAX_PEOPLE = 128;
  localparam int MAX_RESULTS    = 12;
  // one pop per full group of this many people
  localparam int GROUP_SIZE     = 100 / 10;

  localparam logic [1:0] KIND_RANKED = 2'd0;
  localparam logic [1:0] KIND_NONE   = 2'd1;
  localparam logic [1:0] KIND_ZERO   = 2'd2;

  typedef struct packed {
    logic [6:0] degree;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] person_id;
    logic [6:0] contacts;
    logic       final_res;
  } result_t;

  typedef struct packed {
    logic [7:0] id;
    logic [6:0] deg;
  } entry_t;

endpackage

// ----- hdl/heap_top_tenth_selector_unit.sv -----
// Top level of the heap top-tenth selector: sequencer plus heap memory.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------
//   item     | item_valid / item_stall | degree, last
//   result   | result_valid / result_stall | kind, person_id, contacts, final_res
//
// Loading one request runs accept, C parent compares, then the final write.
// C is one per level climbed plus one for a compare that stops the climb below the
// root (none for the first entry), so at most log2 of the fill; a dropped request
// is taken without a write. A pop that ends the run reads and emits the root; any
// other pop also loads the last entry as key, runs C child compares of sift-down
// (both children per cycle on both read ports) and writes it; ST_SEL opens selection.
// Reset clears the fill count and the contact flag; the heap memory is not cleared.
// A stalled result holds the sequencer before the next pop; loading continues
// while a result waits.
module heap_top_tenth_selector_unit #(
  parameter int MAX_PEOPLE = hsel_pkg::DEF_MAX_PEOPLE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  hsel_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output hsel_pkg::result_t result
);
  import hsel_pkg::*;

  localparam int AW = $clog2(MAX_PEOPLE);

  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  entry_t        wdata, rdata_a, rdata_b;

  hsel_ctrl #(
    .MAX_PEOPLE (MAX_PEOPLE),
    .AW         (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .we           (we),
    .waddr        (waddr),
    .wdata        (wdata),
    .raddr_a      (raddr_a),
    .raddr_b      (raddr_b),
    .rdata_a      (rdata_a),
    .rdata_b      (rdata_b)
  );

  hsel_mem #(
    .MAX_PEOPLE (MAX_PEOPLE),
    .AW         (AW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  a_ranked_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_RANKED |-> result.contacts != '0)
    else $error("ranked result with zero contacts");

  a_marker_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != KIND_RANKED |->
      result.final_res && result.person_id == '0 && result.contacts == '0)
    else $error("marker result not final or not zeroed");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result dropped or changed");

endmodule

// ----- hdl/hsel_mem.sv -----
// Heap storage: one write port, two registered read ports.
module hsel_mem #(
  parameter int MAX_PEOPLE = hsel_pkg::DEF_MAX_PEOPLE,
  parameter int AW = $clog2(MAX_PEOPLE)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  hsel_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr_a,
  input  logic [AW-1:0]   raddr_b,
  output hsel_pkg::entry_t rdata_a,
  output hsel_pkg::entry_t rdata_b
);
  import hsel_pkg::*;

  entry_t mem [MAX_PEOPLE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- hdl/hsel_ctrl.sv -----
// Sequencer: sift-up on load, pop and sift-down on selection, result register.
module hsel_ctrl #(
  parameter int MAX_PEOPLE = hsel_pkg::DEF_MAX_PEOPLE,
  parameter int AW = $clog2(MAX_PEOPLE)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  hsel_pkg::item_t  item,
  output logic             result_valid,
  input  logic             result_stall,
  output hsel_pkg::result_t result,
  output logic             we,
  output logic [AW-1:0]    waddr,
  output hsel_pkg::entry_t wdata,
  output logic [AW-1:0]    raddr_a,
  output logic [AW-1:0]    raddr_b,
  input  hsel_pkg::entry_t rdata_a,
  input  hsel_pkg::entry_t rdata_b
);
  import hsel_pkg::*;

  localparam int CW   = $clog2(MAX_PEOPLE + 1);
  localparam int CMW  = (CW > 8) ? CW + 1 : 9;
  localparam int KW   = $clog2(MAX_RESULTS + 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_UP_CMP  = 4'd1;
  localparam logic [3:0] ST_UP_WR   = 4'd2;
  localparam logic [3:0] ST_SEL     = 4'd3;
  localparam logic [3:0] ST_POP_RD  = 4'd4;
  localparam logic [3:0] ST_POP_TOP = 4'd5;
  localparam logic [3:0] ST_DN_KEY  = 4'd6;
  localparam logic [3:0] ST_DN_CMP  = 4'd7;
  localparam logic [3:0] ST_DN_WR   = 4'd8;

  logic [3:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic          any_c, any_c_next;
  entry_t        key, key_next;
  logic [AW-1:0] pos, pos_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [KW-1:0] k, k_next;
  logic          last_r, last_r_next;

  logic          emit;
  result_t       emit_res;
  logic          out_free;
  logic          accept;

  logic [AW-1:0] par;
  logic [CMW-1:0] c0, c1, pick_idx, nc, cnt_w, count_w;
  logic          pick_b;
  entry_t        pick;
  logic [KW-1:0] done;
  logic          more;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;

  assign par      = (pos - AW'(1)) >> 1;
  assign c0       = CMW'({pos, 1'b1});
  assign c1       = c0 + CMW'(1);
  assign cnt_w    = CMW'(cnt);
  assign count_w  = CMW'(count);
  assign pick_b   = (c1 < cnt_w) && (rdata_b.deg > rdata_a.deg);
  assign pick     = pick_b ? rdata_b : rdata_a;
  assign pick_idx = pick_b ? c1 : c0;
  assign nc       = CMW'({pick_idx[AW-1:0], 1'b1});

  // pops done after the current one; another follows while a whole group remains
  assign done = k + KW'(1);
  assign more = (CMW'(done) < CMW'(MAX_RESULTS)) &&
                ((CMW'(done) + CMW'(1)) * CMW'(GROUP_SIZE) <= count_w);

  always_comb begin
    state_next  = state;
    count_next  = count;
    any_c_next  = any_c;
    key_next    = key;
    pos_next    = pos;
    cnt_next    = cnt;
    k_next      = k;
    last_r_next = last_r;
    we          = 1'b0;
    waddr       = pos;
    wdata       = key;
    raddr_a     = '0;
    raddr_b     = '0;
    emit        = 1'b0;
    emit_res    = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          last_r_next = item.last;
          if (count < CW'(MAX_PEOPLE)) begin
            key_next.id  = 8'(count + CW'(1));
            key_next.deg = item.degree;
            pos_next     = AW'(count);
            count_next   = count + CW'(1);
            if (item.degree != '0) begin
              any_c_next = 1'b1;
            end
            if (count == '0) begin
              state_next = ST_UP_WR;
            end else begin
              raddr_a    = AW'((count - CW'(1)) >> 1);
              state_next = ST_UP_CMP;
            end
          end else if (item.last) begin
            // heap full: drop the item, still run selection
            state_next = ST_SEL;
          end
        end
      end
      ST_UP_CMP: begin
        if (rdata_a.deg < key.deg) begin
          we       = 1'b1;
          waddr    = pos;
          wdata    = rdata_a;
          pos_next = par;
          if (par == '0) begin
            state_next = ST_UP_WR;
          end else begin
            raddr_a = (par - AW'(1)) >> 1;
          end
        end else begin
          state_next = ST_UP_WR;
        end
      end
      ST_UP_WR: begin
        we         = 1'b1;
        state_next = last_r ? ST_SEL : ST_IDLE;
      end
      ST_SEL: begin
        if (!any_c) begin
          if (out_free) begin
            emit               = 1'b1;
            emit_res.kind      = KIND_NONE;
            emit_res.final_res = 1'b1;
            count_next         = '0;
            any_c_next         = 1'b0;
            state_next         = ST_IDLE;
          end
        end else begin
          k_next     = '0;
          cnt_next   = count;
          state_next = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        // hold until the result register can take the popped entry
        raddr_a = '0;
        if (out_free) begin
          state_next = ST_POP_TOP;
        end
      end
      ST_POP_TOP: begin
        emit = 1'b1;
        if (rdata_a.deg == '0) begin
          emit_res.kind      = KIND_ZERO;
          emit_res.final_res = 1'b1;
          count_next         = '0;
          any_c_next         = 1'b0;
          state_next         = ST_IDLE;
        end else begin
          emit_res.kind      = KIND_RANKED;
          emit_res.person_id = rdata_a.id;
          emit_res.contacts  = rdata_a.deg;
          emit_res.final_res = !more;
          if (!more) begin
            count_next = '0;
            any_c_next = 1'b0;
            state_next = ST_IDLE;
          end else begin
            raddr_a    = AW'(cnt - CW'(1));
            cnt_next   = cnt - CW'(1);
            state_next = ST_DN_KEY;
          end
        end
      end
      ST_DN_KEY: begin
        key_next = rdata_a;
        pos_next = '0;
        if (cnt > CW'(1)) begin
          raddr_a    = AW'(1);
          raddr_b    = AW'(2);
          state_next = ST_DN_CMP;
        end else begin
          state_next = ST_DN_WR;
        end
      end
      ST_DN_CMP: begin
        if (pick.deg > key.deg) begin
          we       = 1'b1;
          waddr    = pos;
          wdata    = pick;
          pos_next = pick_idx[AW-1:0];
          if (nc < cnt_w) begin
            raddr_a = nc[AW-1:0];
            raddr_b = AW'(nc + CMW'(1));
          end else begin
            state_next = ST_DN_WR;
          end
        end else begin
          state_next = ST_DN_WR;
        end
      end
      ST_DN_WR: begin
        we         = 1'b1;
        k_next     = k + KW'(1);
        state_next = ST_POP_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      any_c <= 1'b0;
      k     <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      any_c <= any_c_next;
      k     <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    key    <= key_next;
    pos    <= pos_next;
    cnt    <= cnt_next;
    last_r <= last_r_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_res;
    end
  end

endmodule

// ----- test/heap_top_tenth_checker.sv -----
// Checker for the heap top-tenth selector: predicts ranked results per request and compares.
module heap_top_tenth_checker #(
  parameter int MAX_PEOPLE = hsel_pkg::DEF_MAX_PEOPLE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  hsel_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  hsel_pkg::result_t result,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hsel_pkg::*;

  entry_t  heap_slots [MAX_PEOPLE];
  int      fill;
  logic    seen_contact;
  result_t ranked_queue [$];

  function automatic void push_ranked(logic [1:0] kind, logic [7:0] pid, logic [6:0] cnt);
    result_t r;
    r.kind      = kind;
    r.person_id = pid;
    r.contacts  = cnt;
    r.final_res = 1'b0;
    ranked_queue.push_back(r);
  endfunction

  // move an entry up while its parent holds a strictly smaller count
  function automatic void raise_entry(int pos);
    entry_t key;
    int     parent;
    key = heap_slots[pos];
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (heap_slots[parent].deg < key.deg) begin
        heap_slots[pos] = heap_slots[parent];
        pos = parent;
      end else begin
        break;
      end
    end
    heap_slots[pos] = key;
  endfunction

  // right child wins only when strictly greater; move only while strictly greater
  function automatic void sink_root(int cnt);
    entry_t key;
    int     hole;
    int     child;
    key   = heap_slots[0];
    hole  = 0;
    child = 1;
    while (child < cnt) begin
      if (child + 1 < cnt && heap_slots[child + 1].deg > heap_slots[child].deg) child++;
      if (heap_slots[child].deg > key.deg) begin
        heap_slots[hole] = heap_slots[child];
        hole  = child;
        child = 2 * hole + 1;
      end else begin
        break;
      end
    end
    heap_slots[hole] = key;
  endfunction

  function automatic void predict_request(item_t req);
    int quota;
    int remaining;
    int k;
    // drop the request once the heap is full
    if (fill < MAX_PEOPLE) begin
      heap_slots[fill].id  = 8'(fill + 1);
      heap_slots[fill].deg = req.degree;
      raise_entry(fill);
      fill++;
      if (req.degree != '0) seen_contact = 1'b1;
    end
    if (!req.last) return;

    if (!seen_contact) begin
      push_ranked(KIND_NONE, '0, '0);
    end else begin
      quota = fill / GROUP_SIZE;
      if (quota < 1) quota = 1;
      if (quota > MAX_RESULTS) quota = MAX_RESULTS;
      remaining = fill;
      for (k = 0; k < quota && k < remaining; k++) begin
        if (heap_slots[0].deg == '0) begin
          push_ranked(KIND_ZERO, '0, '0);
          break;
        end
        push_ranked(KIND_RANKED, heap_slots[0].id, heap_slots[0].deg);
        heap_slots[0] = heap_slots[remaining - 1];
        remaining--;
        sink_root(remaining);
      end
    end
    ranked_queue[ranked_queue.size() - 1].final_res = 1'b1;
    fill         = 0;
    seen_contact = 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      fill         = 0;
      seen_contact = 1'b0;
      fail_count   = 0;
      ranked_queue.delete();
    end else begin
      if (item_valid && !item_stall) predict_request(item);
      if (result_valid && !result_stall) begin
        if (ranked_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result kind %0d id %0d contacts %0d final %0b",
                     $realtime, result.kind, result.person_id, result.contacts,
                     result.final_res);
        end else begin
          want = ranked_queue.pop_front();
          if (result !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: result mismatch: expected kind %0d id %0d contacts %0d ",
                        "final %0b, got kind %0d id %0d contacts %0d final %0b"},
                       $realtime, want.kind, want.person_id, want.contacts,
                       want.final_res, result.kind, result.person_id, result.contacts,
                       result.final_res);
          end
        end
      end
    end
    pending = ranked_queue.size();
  end

endmodule

// ----- test/heap_top_tenth_selector_unit_tb.sv -----
// Testbench top for the heap top-tenth selector: request stimulus, stalls and verdict.
module heap_top_tenth_selector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsel_pkg::*;

  localparam int RANDOM_ITEMS   = 325;
  localparam int TAIL_ITEMS     = 60;
  localparam int TAIL_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int fail_count;
  int pending;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  heap_top_tenth_selector_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  heap_top_tenth_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // stall the result side in bursts
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left   <= 0;
      result_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(1, 11);
    end
  end

  // end the run after too long without any accepted request or result
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_request(input logic [6:0] deg, input logic last_flag);
    if ($urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{degree: deg, last: last_flag};
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_load(input int len, input int zero_pct, input int deg_cap);
    int          i;
    logic [6:0]  deg;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < zero_pct) deg = '0;
      else deg = 7'($urandom_range(0, deg_cap));
      send_request(deg, i == len - 1);
    end
  endtask

  // hold requests until every predicted result has come out
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int items_sent;
    int load_len;
    int zero_pct;
    int deg_cap;
    bit heap_full_done;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    gap_pct   = 20;
    stall_pct = 20;
    // all counts zero, then a single full count
    send_request(7'd0, 1'b1);
    send_request(7'd127, 1'b1);
    // tie at the root must keep the first arrival
    send_request(7'd127, 1'b0);
    send_request(7'd0, 1'b0);
    send_request(7'd127, 1'b1);
    // second pop finds a zero maximum
    send_request(7'd5, 1'b0);
    repeat (18) send_request(7'd0, 1'b0);
    send_request(7'd0, 1'b1);
    wait_drained();

    items_sent     = 0;
    heap_full_done = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      if (RANDOM_ITEMS - items_sent <= TAIL_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 20;
          default: stall_pct = 60;
        endcase
      end
      zero_pct = 0;
      deg_cap  = 127;
      case ($urandom_range(0, 7))
        0: zero_pct = 100;
        1: zero_pct = 80;
        2: deg_cap  = 3;
        default: zero_pct = $urandom_range(0, 30);
      endcase
      if (!heap_full_done && items_sent >= 120) begin
        // overfill the heap so the tail requests are dropped
        load_len       = DEF_MAX_PEOPLE + $urandom_range(1, 8);
        zero_pct       = 20;
        deg_cap        = 127;
        heap_full_done = 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0: load_len = $urandom_range(1, 9);
          1, 2: load_len = $urandom_range(10, 40);
          default: load_len = $urandom_range(41, 90);
        endcase
        if (load_len > RANDOM_ITEMS - items_sent) load_len = RANDOM_ITEMS - items_sent;
      end
      send_load(load_len, zero_pct, deg_cap);
      items_sent += load_len;
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- heap_top_tenth_selector_unit.f -----
hdl/hsel_pkg.sv
hdl/hsel_mem.sv
hdl/hsel_ctrl.sv
hdl/heap_top_tenth_selector_unit.sv
test/heap_top_tenth_checker.sv
test/heap_top_tenth_selector_unit_tb.sv
